FILE: sv/compacting_string_store_macros.svh
`ifndef COMPACTING_STRING_STORE_MACROS_SVH
`define COMPACTING_STRING_STORE_MACROS_SVH

// Check an implication in the same cycle, clocked on i_clk, off while in reset.
`define CSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the following cycle, clocked on i_clk, off while in reset.
`define CSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/csstr_pkg.sv
`default_nettype none
package csstr_pkg;

    localparam int STORE_BYTES  = 1024;
    localparam int MAX_ENTRIES  = 128;
    localparam int STRING_LIMIT = 128;

    localparam int AW  = $clog2(STORE_BYTES);       // store address
    localparam int UW  = $clog2(STORE_BYTES + 1);   // used byte count
    localparam int IW  = $clog2(MAX_ENTRIES);       // entry index
    localparam int CW  = $clog2(MAX_ENTRIES + 1);   // entry count
    localparam int LW  = $clog2(STRING_LIMIT);      // entry length
    localparam int SLW = $clog2(STRING_LIMIT + 1);  // staging length

    typedef enum logic [2:0] {
        CMD_APPEND  = 3'd0,
        CMD_DELETE  = 3'd1,
        CMD_MODIFY  = 3'd2,
        CMD_COMPACT = 3'd3,
        CMD_READ    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_LONG    = 3'd2,
        ST_NOSPACE = 3'd3,
        ST_BADIDX  = 3'd4,
        ST_DELETED = 3'd5
    } t_status;

    typedef struct packed {
        logic [AW-1:0] start;
        logic [LW-1:0] size;
        logic          live;
    } t_entry;

endpackage
`default_nettype wire

FILE: sv/compacting_string_store.sv
// Channel   | Direction | tdata (low bit up)                              | tuser   | tlast
// s (item)  | in        | data_byte[7:0] entry_index[14:8] byte_offset[21:15] | command | last_byte
// m (result)| out       | result_index[6:0] read_byte[14:7] entry_length[21:15]
//           |           | used_bytes[32:22] entry_count[40:33]            | status  | -
//
// A non-final string byte, a rejected append and an unused command are answered from idle.
// A final append byte copies the staged string (S_COPY), a modify looks up then copies (S_LOOK, S_COPY),
// a delete looks up (S_LOOK), a read looks up and fetches (S_LOOK, S_BYTE); the entry table read is registered.
// Compact scans every entry (S_SCAN, S_SENT) and copies each live entry down, one byte a cycle.
// Reset is synchronous, active low; the memories are not cleared (never read unwritten).
// The result sits in an output register; a stalled output holds the block only at its end.
`default_nettype none
module compacting_string_store (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // data_byte, entry_index, byte_offset
    input  wire logic [2:0]  i_s_tuser,   // command
    input  wire logic        i_s_tlast,   // last_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // result_index, read_byte, entry_length,
                                          // used_bytes, entry_count
    output logic [2:0]       o_m_tuser    // status
);

    localparam int AW  = csstr_pkg::AW;
    localparam int UW  = csstr_pkg::UW;
    localparam int IW  = csstr_pkg::IW;
    localparam int CW  = csstr_pkg::CW;
    localparam int LW  = csstr_pkg::LW;
    localparam int SLW = csstr_pkg::SLW;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOOK = 7'b0000010,
        S_COPY = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_SENT = 7'b0010000,
        S_BYTE = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // memories
    logic [7:0]        r_store [csstr_pkg::STORE_BYTES];
    csstr_pkg::t_entry r_table [csstr_pkg::MAX_ENTRIES];
    logic [7:0]        r_stage [csstr_pkg::STRING_LIMIT-1];
    logic [7:0]        r_st_q;
    csstr_pkg::t_entry r_ent_q;
    logic [7:0]        r_stg_q;

    // memory strobes
    logic              st_we;
    logic [AW-1:0]     st_wa;
    logic [7:0]        st_wd;
    logic [AW-1:0]     st_ra;
    logic              en_we;
    logic [IW-1:0]     en_wa;
    csstr_pkg::t_entry en_wd;
    logic [IW-1:0]     en_ra;
    logic              stg_we;
    logic [LW-1:0]     stg_wa;
    logic [LW-1:0]     stg_ra;

    // control registers
    t_state              r_state, n_state;
    logic [SLW-1:0]      r_stg_len, n_stg_len;
    logic [UW-1:0]       r_bump, n_bump;
    logic [CW-1:0]       r_count, n_count;
    csstr_pkg::t_cmd     r_cmd, n_cmd;
    logic [IW-1:0]       r_idx, n_idx;
    logic [LW-1:0]       r_off, n_off;
    logic [SLW-1:0]      r_len, n_len;
    // pending result
    csstr_pkg::t_status  r_res_st, n_res_st;
    logic [IW-1:0]       r_res_idx, n_res_idx;
    logic [7:0]          r_res_byte, n_res_byte;
    logic [LW-1:0]       r_res_len, n_res_len;
    // copy engine
    logic [AW-1:0]       r_cp_src, n_cp_src;
    logic [AW-1:0]       r_cp_dst, n_cp_dst;
    logic [LW-1:0]       r_cp_len, n_cp_len;
    logic [LW-1:0]       r_cp_j, n_cp_j;
    logic [AW-1:0]       r_cp_wa, n_cp_wa;
    logic                r_cp_pend, n_cp_pend;
    logic                r_cp_store, n_cp_store;
    logic                r_cp_ret, n_cp_ret;
    // compaction walk
    logic [CW-1:0]       r_i, n_i;
    logic [UW-1:0]       r_cdst, n_cdst;
    logic [CW-1:0]       r_cn, n_cn;
    // output register
    logic                r_ov, n_ov;
    csstr_pkg::t_status  r_o_st, n_o_st;
    logic [IW-1:0]       r_o_idx, n_o_idx;
    logic [7:0]          r_o_byte, n_o_byte;
    logic [LW-1:0]       r_o_len, n_o_len;
    logic [UW-1:0]       r_o_used, n_o_used;
    logic [CW-1:0]       r_o_cnt, n_o_cnt;

    // item fields
    csstr_pkg::t_cmd in_cmd;
    logic [7:0]      in_byte;
    logic [IW-1:0]   in_idx;
    logic [LW-1:0]   in_off;
    logic            accept;
    logic            out_free;
    logic            in_valid;
    logic [SLW-1:0]  len_fin;
    logic            cp_issue;

    assign in_cmd   = csstr_pkg::t_cmd'(i_s_tuser);
    assign in_byte  = i_s_tdata[7:0];
    assign in_idx   = i_s_tdata[14:8];
    assign in_off   = i_s_tdata[21:15];
    assign out_free = !r_ov || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign accept   = i_s_tvalid && o_s_tready;
    assign in_valid = CW'(in_idx) < r_count;
    assign len_fin  = (r_stg_len < SLW'(csstr_pkg::STRING_LIMIT)) ? r_stg_len + 1'b1
                                                                   : r_stg_len;
    assign cp_issue = r_cp_j < r_cp_len;

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_o_st;
    assign o_m_tdata  = {7'd0, r_o_cnt, r_o_used, r_o_len, r_o_byte, r_o_idx};

    // next state, memory strobes
    always_comb begin
        n_state    = r_state;
        n_stg_len  = r_stg_len;
        n_bump     = r_bump;
        n_count    = r_count;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_off      = r_off;
        n_len      = r_len;
        n_res_st   = r_res_st;
        n_res_idx  = r_res_idx;
        n_res_byte = r_res_byte;
        n_res_len  = r_res_len;
        n_cp_src   = r_cp_src;
        n_cp_dst   = r_cp_dst;
        n_cp_len   = r_cp_len;
        n_cp_j     = r_cp_j;
        n_cp_wa    = r_cp_wa;
        n_cp_pend  = r_cp_pend;
        n_cp_store = r_cp_store;
        n_cp_ret   = r_cp_ret;
        n_i        = r_i;
        n_cdst     = r_cdst;
        n_cn       = r_cn;
        n_ov       = r_ov && !i_m_tready;
        n_o_st     = r_o_st;
        n_o_idx    = r_o_idx;
        n_o_byte   = r_o_byte;
        n_o_len    = r_o_len;
        n_o_used   = r_o_used;
        n_o_cnt    = r_o_cnt;
        st_we  = 1'b0;
        st_wa  = r_cp_wa;
        st_wd  = r_cp_store ? r_st_q : r_stg_q;
        st_ra  = '0;
        en_we  = 1'b0;
        en_wa  = '0;
        en_wd  = '0;
        en_ra  = '0;
        stg_we = 1'b0;
        stg_wa = r_stg_len[LW-1:0];
        stg_ra = r_cp_j;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = in_cmd;
                    n_idx = in_idx;
                    n_off = in_off;
                    // immediate result unless a later state overrides it
                    n_o_st   = csstr_pkg::ST_OK;
                    n_o_idx  = '0;
                    n_o_byte = '0;
                    n_o_len  = '0;
                    n_o_used = r_bump;
                    n_o_cnt  = r_count;
                    n_ov     = 1'b1;
                    case (in_cmd)
                        csstr_pkg::CMD_APPEND, csstr_pkg::CMD_MODIFY: begin
                            stg_we = r_stg_len < SLW'(csstr_pkg::STRING_LIMIT - 1);
                            n_stg_len = len_fin;
                            if (i_s_tlast) begin
                                n_stg_len = '0;
                                n_len = len_fin;
                                n_cp_j = '0;
                                n_cp_pend = 1'b0;
                                n_cp_store = 1'b0;
                                n_cp_ret = 1'b0;
                                n_cp_len = len_fin[LW-1:0];
                                if (in_cmd == csstr_pkg::CMD_APPEND) begin
                                    if (r_count >= CW'(csstr_pkg::MAX_ENTRIES)) begin
                                        n_o_st = csstr_pkg::ST_FULL;
                                    end else if (len_fin >= SLW'(csstr_pkg::STRING_LIMIT)) begin
                                        n_o_st = csstr_pkg::ST_LONG;
                                    end else if ((r_bump + UW'(len_fin))
                                                 > UW'(csstr_pkg::STORE_BYTES)) begin
                                        n_o_st = csstr_pkg::ST_NOSPACE;
                                    end else begin
                                        // new entry at the bump pointer
                                        en_we = 1'b1;
                                        en_wa = r_count[IW-1:0];
                                        en_wd = '{start: r_bump[AW-1:0],
                                                  size: len_fin[LW-1:0], live: 1'b1};
                                        n_cp_dst = r_bump[AW-1:0];
                                        n_bump = r_bump + UW'(len_fin);
                                        n_count = r_count + 1'b1;
                                        n_res_st = csstr_pkg::ST_OK;
                                        n_res_idx = r_count[IW-1:0];
                                        n_res_byte = '0;
                                        n_res_len = len_fin[LW-1:0];
                                        n_ov = r_ov && !i_m_tready;
                                        n_state = S_COPY;
                                    end
                                end else if (!in_valid) begin
                                    n_o_st = csstr_pkg::ST_BADIDX;
                                    n_o_idx = in_idx;
                                end else begin
                                    en_ra = in_idx;
                                    n_ov = r_ov && !i_m_tready;
                                    n_state = S_LOOK;
                                end
                            end
                        end
                        csstr_pkg::CMD_DELETE, csstr_pkg::CMD_READ: begin
                            if (!in_valid) begin
                                n_o_st = csstr_pkg::ST_BADIDX;
                                n_o_idx = in_idx;
                            end else begin
                                en_ra = in_idx;
                                n_ov = r_ov && !i_m_tready;
                                n_state = S_LOOK;
                            end
                        end
                        csstr_pkg::CMD_COMPACT: begin
                            n_i = '0;
                            n_cdst = '0;
                            n_cn = '0;
                            n_ov = r_ov && !i_m_tready;
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOOK: begin
                n_res_idx = r_idx;
                n_res_byte = '0;
                n_res_len = r_ent_q.size;
                n_res_st = csstr_pkg::ST_OK;
                n_state = S_DONE;
                case (r_cmd)
                    csstr_pkg::CMD_DELETE: begin
                        en_we = 1'b1;
                        en_wa = r_idx;
                        en_wd = '{start: r_ent_q.start, size: r_ent_q.size, live: 1'b0};
                        if (!r_ent_q.live) n_res_st = csstr_pkg::ST_DELETED;
                    end
                    csstr_pkg::CMD_READ: begin
                        if (!r_ent_q.live) begin
                            n_res_st = csstr_pkg::ST_DELETED;
                        end else if (r_off >= r_ent_q.size) begin
                            n_res_st = csstr_pkg::ST_BADIDX;
                        end else begin
                            st_ra = r_ent_q.start + AW'(r_off);
                            n_state = S_BYTE;
                        end
                    end
                    csstr_pkg::CMD_MODIFY: begin
                        if (!r_ent_q.live) begin
                            n_res_st = csstr_pkg::ST_DELETED;
                        end else if (r_len >= SLW'(csstr_pkg::STRING_LIMIT)) begin
                            n_res_st = csstr_pkg::ST_LONG;
                        end else if (r_len <= SLW'(r_ent_q.size)) begin
                            // rewrite in place
                            en_we = 1'b1;
                            en_wa = r_idx;
                            en_wd = '{start: r_ent_q.start, size: r_len[LW-1:0], live: 1'b1};
                            n_cp_dst = r_ent_q.start;
                            n_res_len = r_len[LW-1:0];
                            n_state = S_COPY;
                        end else if ((r_bump + UW'(r_len)) > UW'(csstr_pkg::STORE_BYTES)) begin
                            n_res_st = csstr_pkg::ST_NOSPACE;
                        end else begin
                            // move to the bump pointer
                            en_we = 1'b1;
                            en_wa = r_idx;
                            en_wd = '{start: r_bump[AW-1:0], size: r_len[LW-1:0], live: 1'b1};
                            n_cp_dst = r_bump[AW-1:0];
                            n_bump = r_bump + UW'(r_len);
                            n_res_len = r_len[LW-1:0];
                            n_state = S_COPY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_BYTE: begin
                n_res_byte = r_st_q;
                n_state = S_DONE;
            end
            S_COPY: begin
                // issue one read, retire the previous one
                st_ra = r_cp_src + AW'(r_cp_j);
                st_we = r_cp_pend;
                n_cp_pend = cp_issue;
                if (cp_issue) begin
                    n_cp_wa = r_cp_dst + AW'(r_cp_j);
                    n_cp_j = r_cp_j + 1'b1;
                end
                if (!cp_issue && !r_cp_pend) begin
                    n_state = r_cp_ret ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (r_i < r_count) begin
                    en_ra = r_i[IW-1:0];
                    n_state = S_SENT;
                end else begin
                    n_bump = r_cdst;
                    n_count = r_cn;
                    n_res_st = csstr_pkg::ST_OK;
                    n_res_idx = '0;
                    n_res_byte = '0;
                    n_res_len = '0;
                    n_state = S_DONE;
                end
            end
            S_SENT: begin
                n_i = r_i + 1'b1;
                n_state = S_SCAN;
                if (r_ent_q.live) begin
                    // slide the live entry down to the compaction pointer
                    en_we = 1'b1;
                    en_wa = r_cn[IW-1:0];
                    en_wd = '{start: r_cdst[AW-1:0], size: r_ent_q.size, live: 1'b1};
                    n_cp_src = r_ent_q.start;
                    n_cp_dst = r_cdst[AW-1:0];
                    n_cp_len = r_ent_q.size;
                    n_cp_j = '0;
                    n_cp_pend = 1'b0;
                    n_cp_store = 1'b1;
                    n_cp_ret = 1'b1;
                    n_cdst = r_cdst + UW'(r_ent_q.size);
                    n_cn = r_cn + 1'b1;
                    n_state = S_COPY;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_o_st = r_res_st;
                    n_o_idx = r_res_idx;
                    n_o_byte = r_res_byte;
                    n_o_len = r_res_len;
                    n_o_used = r_bump;
                    n_o_cnt = r_count;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stg_len <= '0;
            r_bump    <= '0;
            r_count   <= '0;
            r_cp_pend <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_stg_len <= n_stg_len;
            r_bump    <= n_bump;
            r_count   <= n_count;
            r_cp_pend <= n_cp_pend;
            r_ov      <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_off      <= n_off;
        r_len      <= n_len;
        r_res_st   <= n_res_st;
        r_res_idx  <= n_res_idx;
        r_res_byte <= n_res_byte;
        r_res_len  <= n_res_len;
        r_cp_src   <= n_cp_src;
        r_cp_dst   <= n_cp_dst;
        r_cp_len   <= n_cp_len;
        r_cp_j     <= n_cp_j;
        r_cp_wa    <= n_cp_wa;
        r_cp_store <= n_cp_store;
        r_cp_ret   <= n_cp_ret;
        r_i        <= n_i;
        r_cdst     <= n_cdst;
        r_cn       <= n_cn;
        r_o_st     <= n_o_st;
        r_o_idx    <= n_o_idx;
        r_o_byte   <= n_o_byte;
        r_o_len    <= n_o_len;
        r_o_used   <= n_o_used;
        r_o_cnt    <= n_o_cnt;
    end

    // byte store; pass a same-address write through to the read data
    always_ff @(posedge i_clk) begin
        if (st_we) r_store[st_wa] <= st_wd;
        if (st_we && (st_wa == st_ra)) r_st_q <= st_wd;
        else r_st_q <= r_store[st_ra];
    end

    // entry table
    always_ff @(posedge i_clk) begin
        if (en_we) r_table[en_wa] <= en_wd;
        r_ent_q <= r_table[en_ra];
    end

    // staging buffer
    always_ff @(posedge i_clk) begin
        if (stg_we) r_stage[stg_wa] <= in_byte;
        r_stg_q <= r_stage[stg_ra];
    end

endmodule
`default_nettype wire

FILE: sv/csstr_checker.sv
`default_nettype none
`include "compacting_string_store_macros.svh"
module csstr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [47:0] o_m_tdata,
    input wire logic [2:0]  o_m_tuser
);

    // a stalled result holds
    `CSS_ASSERT_NEXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed under stall")

    // bump pointer stays inside the store
    `CSS_ASSERT_IMPLY(a_used, o_m_tvalid, o_m_tdata[32:22] <= 11'(csstr_pkg::STORE_BYTES), "used bytes beyond store")

    // entry count stays inside the table
    `CSS_ASSERT_IMPLY(a_count, o_m_tvalid, o_m_tdata[40:33] <= 8'(csstr_pkg::MAX_ENTRIES), "entry count beyond table")

    // table full is reported only with a full table
    `CSS_ASSERT_IMPLY(a_full, o_m_tvalid && (o_m_tuser == csstr_pkg::ST_FULL), o_m_tdata[40:33] == 8'(csstr_pkg::MAX_ENTRIES), "table full with free slots")

endmodule

bind compacting_string_store csstr_checker u_csstr_checker (.*);
`default_nettype wire
